/* sv/qs_pkg.sv */
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies; imported by every module of the block except qs_checker.
package qs_pkg;

    // Datapath widths
    localparam int XW          = 34;   // CORDIC x/y, signed, Q.30
    localparam int ZW          = 20;   // CORDIC angle accumulator, signed, Q.16
    localparam int AW          = 18;   // angle in [0, pi], unsigned, Q.16
    localparam int SQRT_STEPS  = 32;   // digit steps of the 64-bit integer root
    localparam int WQ_W        = 24;   // weight quotient bits
    localparam int WREM_W      = 55;   // weight divider remainder
    localparam int WD_W        = 31;   // weight divisor (sine, Q.30)
    localparam int RQ_W        = 16;   // output quotient bits
    localparam int RREM_W      = 48;   // output divider remainder
    localparam int RD_W        = 32;   // output divisor (vector length)
    localparam int TAB_LEN     = 24;

    // Angle and value constants
    localparam logic [AW-1:0]  ANG_PI      = 18'd205887;
    localparam logic [AW-1:0]  ANG_HALF_PI = 18'd102944;
    localparam logic [XW-1:0]  GAIN_Q30    = 34'd652032874;
    localparam logic [XW-1:0]  ONE_Q30     = 34'd1073741824;
    localparam logic [WQ_W-1:0] WEIGHT_MAX = 24'd16777215;

    // round(atan(2^-i) * 2^16)
    localparam logic [15:0] ATAN_TAB [TAB_LEN] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024,  16'd512,   16'd256,   16'd128,  16'd64,   16'd32,
        16'd16,    16'd8,     16'd4,     16'd2,    16'd1,    16'd0,
        16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0
    };

    // Per-request side data carried alongside the arithmetic chains
    typedef struct packed {
        logic [3:0][15:0] qa;        // start quaternion
        logic [3:0][15:0] qb;        // end quaternion
        logic [15:0]      t;         // clamped fraction
        logic [30:0]      x;         // |dot| in Q.30
        logic             neg;       // dot was negative
        logic             below_lim; // angle below limit
        logic [1:0]       wov;       // weight quotient overflow
        logic             wzero;     // sin(alpha) came out zero
        logic [3:0]       sgn;       // sign of each weighted sum
        logic [3:0][29:0] mag;       // normalized magnitudes
        logic [3:0]       rov;       // output quotient overflow
        logic             lzero;     // zero length sum
    } side_t;

endpackage

/* sv/qs_sqrt_cell.sv */
// One digit step of the restoring 64-bit integer square root.
// Depends on qs_pkg.
module qs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v_in,
    input  logic [63:0] r_in,
    output logic [63:0] v_out,
    output logic [63:0] r_out
);
    import qs_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic [63:0] v_next;
    logic [63:0] r_next;
    logic [63:0] v_reg;
    logic [63:0] r_reg;

    // compare and subtract one digit
    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

/* sv/qs_cordic_cell.sv */
// One micro-rotation of a CORDIC, vectoring or rotation mode.
// Depends on qs_pkg for widths and the arctangent table.
module qs_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [qs_pkg::XW-1:0] x_in,
    input  logic signed [qs_pkg::XW-1:0] y_in,
    input  logic signed [qs_pkg::ZW-1:0] z_in,
    output logic signed [qs_pkg::XW-1:0] x_out,
    output logic signed [qs_pkg::XW-1:0] y_out,
    output logic signed [qs_pkg::ZW-1:0] z_out
);
    import qs_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed({4'b0, ATAN_TAB[STEP]});

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 up;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    // direction: drive y to zero when vectoring, z to zero when rotating
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        up = VECTOR ? ~y_in[XW-1] : z_in[ZW-1];
        if (up)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* sv/qs_div_cell.sv */
// One quotient bit of a restoring divider.
// Depends on qs_pkg.
module qs_div_cell #(
    parameter int STEP = 0,
    parameter int RW   = 48,
    parameter int DW   = 32,
    parameter int QW   = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [DW-1:0] d_in,
    input  logic [QW-1:0] q_in,
    output logic [RW-1:0] rem_out,
    output logic [DW-1:0] d_out,
    output logic [QW-1:0] q_out
);
    import qs_pkg::*;

    logic [RW-1:0] sub;
    logic          ge;
    logic [RW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [QW-1:0] q_reg;

    // trial subtract of the shifted divisor
    always_comb
    begin
        sub = {{(RW-DW){1'b0}}, d_in} << STEP;
        ge  = (rem_in >= sub);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? (rem_in - sub) : rem_in;
            d_reg   <= d_in;
            q_reg   <= {q_in[QW-2:0], ge};
        end
    end

    assign rem_out = rem_reg;
    assign d_out   = d_reg;
    assign q_out   = q_reg;

endmodule

/* sv/qs_delay.sv */
// Shift line for the valid flag and side data beside an arithmetic chain.
// Depends on qs_pkg for side_t.
module qs_delay #(
    parameter int DEPTH = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  qs_pkg::side_t side_in,
    output logic          vld_out,
    output qs_pkg::side_t side_out
);
    import qs_pkg::*;

    logic [DEPTH-1:0] vld_reg;
    side_t            side_reg [DEPTH];

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // side data shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign vld_out  = vld_reg[DEPTH-1];
    assign side_out = side_reg[DEPTH-1];

endmodule

/* sv/quaternion_slerp.sv */
// Quaternion slerp, fully pipelined: one request is accepted every cycle while
// the output is taken. The pipe depth is set by the two 32-cell square root
// chains, the vectoring and sine CORDIC chains of ANGLE_ITERATIONS cells, and
// the 24- and 16-cell divider chains. The whole pipe holds while a finished
// result waits on out_ready. min_angle is written through cfg_wr_en/cfg_wr_data
// (reset value 1) and must only change while idle.
// Depends on qs_pkg and the qs_* cell and delay modules.
module quaternion_slerp #(
    parameter int ANGLE_ITERATIONS = 16,
    parameter int FRAC_BITS        = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] from_w,
    input  logic signed [15:0] from_x,
    input  logic signed [15:0] from_y,
    input  logic signed [15:0] from_z,
    input  logic signed [15:0] to_w,
    input  logic signed [15:0] to_x,
    input  logic signed [15:0] to_y,
    input  logic signed [15:0] to_z,
    input  logic [15:0]        fraction,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_w,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic               small_angle
);
    import qs_pkg::*;

    localparam int NIT  = ANGLE_ITERATIONS;
    localparam int DOTF = 2 * FRAC_BITS;

    logic        en;
    logic [15:0] min_angle_reg;

    // stage A: products
    side_t              a_side_next, a_side_reg;
    logic               a_vld_reg;
    logic signed [31:0] a_prod_reg [4];
    // stage B: dot, clamp, rescale
    logic signed [33:0] dot_sum;
    logic signed [63:0] dot_clamp;
    logic signed [63:0] dot_scaled;
    logic signed [31:0] d30;
    side_t              b_side_next, b_side_reg;
    logic               b_vld_reg;
    // stage C: square partial products
    side_t       c_side_reg;
    logic        c_vld_reg;
    logic [31:0] c_hh_reg;
    logic [30:0] c_hl_reg;
    logic [29:0] c_ll_reg;
    // stage D: 1 - d^2
    side_t       d_side_reg;
    logic        d_vld_reg;
    logic [63:0] d_rad_reg;
    // first root chain
    logic [63:0] s1_v [0:SQRT_STEPS];
    logic [63:0] s1_r [0:SQRT_STEPS];
    side_t       s1_side;
    logic        s1_vld;
    // vectoring chain
    logic signed [XW-1:0] vx [0:NIT];
    logic signed [XW-1:0] vy [0:NIT];
    logic signed [ZW-1:0] vz [0:NIT];
    side_t                v_side;
    logic                 v_vld;
    // stage E: alpha and limit check
    logic signed [ZW-1:0] z_clamp;
    logic [AW-1:0]        alpha;
    side_t                e_side_next, e_side_reg;
    logic                 e_vld_reg;
    logic [AW-1:0]        e_alpha_reg;
    // stage F: t*alpha
    side_t         f_side_reg;
    logic          f_vld_reg;
    logic [AW-1:0] f_alpha_reg;
    logic [33:0]   f_tprod_reg;
    // stage G: t*alpha rounded, remainder angle
    logic [33:0]   g_ta_full;
    side_t         g_side_reg;
    logic          g_vld_reg;
    logic [AW-1:0] g_ang_reg [3];
    // stage H: fold to [0, pi/2]
    side_t                h_side_reg;
    logic                 h_vld_reg;
    logic signed [ZW-1:0] h_z_reg [3];
    // sine chains (lane 0 alpha, 1 rest, 2 t*alpha)
    logic signed [XW-1:0] sx [0:2][0:NIT];
    logic signed [XW-1:0] sy [0:2][0:NIT];
    logic signed [ZW-1:0] sz [0:2][0:NIT];
    side_t                sn_side;
    logic                 sn_vld;
    // stage I: clamp sines
    side_t       i_side_reg;
    logic        i_vld_reg;
    logic [30:0] i_sin_reg [3];
    // stage J: weight divider setup
    side_t             j_side_next, j_side_reg;
    logic              j_vld_reg;
    logic [WREM_W-1:0] j_rem_reg [2];
    logic [WD_W-1:0]   j_d_reg;
    // weight divider chains
    logic [WREM_W-1:0] w_rem [0:1][0:WQ_W];
    logic [WD_W-1:0]   w_d   [0:1][0:WQ_W];
    logic [WQ_W-1:0]   w_q   [0:1][0:WQ_W];
    side_t             wd_side;
    logic              wd_vld;
    // stage K: weights
    side_t           k_side_reg;
    logic            k_vld_reg;
    logic [WQ_W-1:0] k_w_reg [2];
    // stage L: weighted products
    side_t              l_side_reg;
    logic               l_vld_reg;
    logic signed [40:0] l_pa_reg [4];
    logic signed [40:0] l_pb_reg [4];
    // stage M: sums and magnitudes
    logic signed [41:0] m_sum [4];
    side_t              m_side_next, m_side_reg;
    logic               m_vld_reg;
    logic [40:0]        m_mag_reg [4];
    // stage N: shift count
    logic [40:0] n_or;
    logic [3:0]  n_k_next;
    side_t       n_side_reg;
    logic        n_vld_reg;
    logic [40:0] n_mag_reg [4];
    logic [3:0]  n_k_reg;
    // stage O: scaled magnitudes
    side_t       o_side_next, o_side_reg;
    logic        o_vld_reg;
    // stage P: squares
    side_t       p_side_reg;
    logic        p_vld_reg;
    logic [59:0] p_sq_reg [4];
    // stage Q: sum of squares
    side_t       q_side_reg;
    logic        q_vld_reg;
    logic [63:0] q_sum_reg;
    // second root chain
    logic [63:0] s2_v [0:SQRT_STEPS];
    logic [63:0] s2_r [0:SQRT_STEPS];
    side_t       s2_side;
    logic        s2_vld;
    // stage R: output divider setup
    logic [63:0]       r_num [4];
    logic [63:0]       r_lim;
    side_t             r_side_next, r_side_reg;
    logic              r_vld_reg;
    logic [RREM_W-1:0] r_rem_reg [4];
    logic [RD_W-1:0]   r_len_reg;
    // output divider chains
    logic [RREM_W-1:0] o_rem [0:3][0:RQ_W];
    logic [RD_W-1:0]   o_d   [0:3][0:RQ_W];
    logic [RQ_W-1:0]   o_q   [0:3][0:RQ_W];
    side_t             od_side;
    logic              od_vld;
    // stage S: output register
    logic [3:0][15:0] out_next;
    logic [3:0][15:0] out_q_reg;
    logic             out_small_reg;
    logic             out_valid_reg;

    // Global advance: the pipe moves unless a result is held
    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            min_angle_reg <= cfg_wr_data;
        end
    end

    // Valid flags of the single stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            e_vld_reg     <= 1'b0;
            f_vld_reg     <= 1'b0;
            g_vld_reg     <= 1'b0;
            h_vld_reg     <= 1'b0;
            i_vld_reg     <= 1'b0;
            j_vld_reg     <= 1'b0;
            k_vld_reg     <= 1'b0;
            l_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            n_vld_reg     <= 1'b0;
            o_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            q_vld_reg     <= 1'b0;
            r_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= v_vld;
            f_vld_reg     <= e_vld_reg;
            g_vld_reg     <= f_vld_reg;
            h_vld_reg     <= g_vld_reg;
            i_vld_reg     <= sn_vld;
            j_vld_reg     <= i_vld_reg;
            k_vld_reg     <= wd_vld;
            l_vld_reg     <= k_vld_reg;
            m_vld_reg     <= l_vld_reg;
            n_vld_reg     <= m_vld_reg;
            o_vld_reg     <= n_vld_reg;
            p_vld_reg     <= o_vld_reg;
            q_vld_reg     <= p_vld_reg;
            r_vld_reg     <= s2_vld;
            out_valid_reg <= od_vld;
        end
    end

    // Stage A: capture request, component products
    always_comb
    begin
        a_side_next       = '0;
        a_side_next.qa[0] = from_w;
        a_side_next.qa[1] = from_x;
        a_side_next.qa[2] = from_y;
        a_side_next.qa[3] = from_z;
        a_side_next.qb[0] = to_w;
        a_side_next.qb[1] = to_x;
        a_side_next.qb[2] = to_y;
        a_side_next.qb[3] = to_z;
        a_side_next.t     = (fraction > 16'd32768) ? 16'd32768 : fraction;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg    <= a_side_next;
            a_prod_reg[0] <= from_w * to_w;
            a_prod_reg[1] <= from_x * to_x;
            a_prod_reg[2] <= from_y * to_y;
            a_prod_reg[3] <= from_z * to_z;
        end
    end

    // Stage B: dot product, clamp to +-1, rescale to Q.30
    always_comb
    begin
        dot_sum = 34'(a_prod_reg[0]) + 34'(a_prod_reg[1])
                + 34'(a_prod_reg[2]) + 34'(a_prod_reg[3]);
        if (64'(dot_sum) > (64'sd1 <<< DOTF))
            dot_clamp = 64'sd1 <<< DOTF;
        else if (64'(dot_sum) < -(64'sd1 <<< DOTF))
            dot_clamp = -(64'sd1 <<< DOTF);
        else
            dot_clamp = 64'(dot_sum);
    end

    if (DOTF > 30) begin : g_scale_down
        assign dot_scaled = (dot_clamp + (64'sd1 <<< (DOTF - 31))) >>> (DOTF - 30);
    end
    else begin : g_scale_up
        assign dot_scaled = dot_clamp <<< (30 - DOTF);
    end

    always_comb
    begin
        d30             = dot_scaled[31:0];
        b_side_next     = a_side_reg;
        b_side_next.neg = d30[31];
        b_side_next.x   = d30[31] ? 31'(-d30) : d30[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= b_side_next;
        end
    end

    // Stage C: x^2 as three partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= b_side_reg;
            c_hh_reg   <= b_side_reg.x[30:15] * b_side_reg.x[30:15];
            c_hl_reg   <= b_side_reg.x[30:15] * b_side_reg.x[14:0];
            c_ll_reg   <= b_side_reg.x[14:0] * b_side_reg.x[14:0];
        end
    end

    // Stage D: radicand 1 - x^2 in Q.60
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= c_side_reg;
            d_rad_reg  <= (64'd1 << 60) - (64'({c_hh_reg, 30'b0})
                        + 64'({c_hl_reg, 16'b0}) + 64'(c_ll_reg));
        end
    end

    // First root chain: y = sqrt(1 - x^2)
    assign s1_v[0] = d_rad_reg;
    assign s1_r[0] = '0;
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt1
        qs_sqrt_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (s1_v[k]),
            .r_in  (s1_r[k]),
            .v_out (s1_v[k+1]),
            .r_out (s1_r[k+1])
        );
    end

    qs_delay #(.DEPTH(SQRT_STEPS)) u_dly_sqrt1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (d_vld_reg),
        .side_in  (d_side_reg),
        .vld_out  (s1_vld),
        .side_out (s1_side)
    );

    // Vectoring chain: atan(y/x) = acos(|dot|)
    assign vx[0] = $signed({{(XW-31){1'b0}}, s1_side.x});
    assign vy[0] = $signed({{(XW-32){1'b0}}, s1_r[SQRT_STEPS][31:0]});
    assign vz[0] = '0;
    for (genvar k = 0; k < NIT; k++) begin : g_vec
        qs_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_cell (
            .clk   (clk),
            .en    (en),
            .x_in  (vx[k]),
            .y_in  (vy[k]),
            .z_in  (vz[k]),
            .x_out (vx[k+1]),
            .y_out (vy[k+1]),
            .z_out (vz[k+1])
        );
    end

    qs_delay #(.DEPTH(NIT)) u_dly_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s1_vld),
        .side_in  (s1_side),
        .vld_out  (v_vld),
        .side_out (v_side)
    );

    // Stage E: clamp to [0, pi/2], mirror for a negative dot, compare limit
    always_comb
    begin
        if (vz[NIT] < 0)
            z_clamp = '0;
        else if (vz[NIT] > $signed({2'b0, ANG_HALF_PI}))
            z_clamp = $signed({2'b0, ANG_HALF_PI});
        else
            z_clamp = vz[NIT];
        alpha = v_side.neg ? (ANG_PI - z_clamp[AW-1:0]) : z_clamp[AW-1:0];
        e_side_next           = v_side;
        e_side_next.below_lim = (alpha < {2'b0, min_angle_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg  <= e_side_next;
            e_alpha_reg <= alpha;
        end
    end

    // Stage F: t * alpha
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg  <= e_side_reg;
            f_alpha_reg <= e_alpha_reg;
            f_tprod_reg <= e_side_reg.t * e_alpha_reg;
        end
    end

    // Stage G: round t*alpha, remaining angle
    assign g_ta_full = (f_tprod_reg + 34'd16384) >> 15;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg   <= f_side_reg;
            g_ang_reg[0] <= f_alpha_reg;
            g_ang_reg[1] <= f_alpha_reg - g_ta_full[AW-1:0];
            g_ang_reg[2] <= g_ta_full[AW-1:0];
        end
    end

    // Stage H: fold each angle into [0, pi/2]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_side_reg <= g_side_reg;
            for (int l = 0; l < 3; l++)
            begin
                h_z_reg[l] <= $signed({2'b0, (g_ang_reg[l] > ANG_HALF_PI)
                              ? (ANG_PI - g_ang_reg[l]) : g_ang_reg[l]});
            end
        end
    end

    // Sine chains, three lanes in step
    for (genvar l = 0; l < 3; l++) begin : g_sin_lane
        assign sx[l][0] = $signed(GAIN_Q30);
        assign sy[l][0] = '0;
        assign sz[l][0] = h_z_reg[l];
        for (genvar k = 0; k < NIT; k++) begin : g_sin
            qs_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (sx[l][k]),
                .y_in  (sy[l][k]),
                .z_in  (sz[l][k]),
                .x_out (sx[l][k+1]),
                .y_out (sy[l][k+1]),
                .z_out (sz[l][k+1])
            );
        end
    end

    qs_delay #(.DEPTH(NIT)) u_dly_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (h_vld_reg),
        .side_in  (h_side_reg),
        .vld_out  (sn_vld),
        .side_out (sn_side)
    );

    // Stage I: clamp sines to [0, 1]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_side_reg <= sn_side;
            for (int l = 0; l < 3; l++)
            begin
                if (sy[l][NIT] < 0)
                    i_sin_reg[l] <= '0;
                else if (sy[l][NIT] > $signed(ONE_Q30))
                    i_sin_reg[l] <= ONE_Q30[30:0];
                else
                    i_sin_reg[l] <= sy[l][NIT][30:0];
            end
        end
    end

    // Stage J: weight divider setup and saturation check
    always_comb
    begin
        j_side_next        = i_side_reg;
        j_side_next.wzero  = (i_sin_reg[0] == '0);
        j_side_next.wov[0] = ({8'b0, i_sin_reg[1]} >= {i_sin_reg[0], 8'b0});
        j_side_next.wov[1] = ({8'b0, i_sin_reg[2]} >= {i_sin_reg[0], 8'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_side_reg   <= j_side_next;
            j_d_reg      <= i_sin_reg[0];
            j_rem_reg[0] <= {8'b0, i_sin_reg[1], 16'b0};
            j_rem_reg[1] <= {8'b0, i_sin_reg[2], 16'b0};
        end
    end

    // Weight divider chains
    for (genvar l = 0; l < 2; l++) begin : g_wdiv_lane
        assign w_rem[l][0] = j_rem_reg[l];
        assign w_d[l][0]   = j_d_reg;
        assign w_q[l][0]   = '0;
        for (genvar k = 0; k < WQ_W; k++) begin : g_wdiv
            qs_div_cell #(
                .STEP (WQ_W - 1 - k),
                .RW   (WREM_W),
                .DW   (WD_W),
                .QW   (WQ_W)
            ) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (w_rem[l][k]),
                .d_in    (w_d[l][k]),
                .q_in    (w_q[l][k]),
                .rem_out (w_rem[l][k+1]),
                .d_out   (w_d[l][k+1]),
                .q_out   (w_q[l][k+1])
            );
        end
    end

    qs_delay #(.DEPTH(WQ_W)) u_dly_wdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (j_vld_reg),
        .side_in  (j_side_reg),
        .vld_out  (wd_vld),
        .side_out (wd_side)
    );

    // Stage K: weights, linear when the sine vanished
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_side_reg <= wd_side;
            if (wd_side.wzero)
            begin
                k_w_reg[0] <= 24'((18'd32768 - 18'(wd_side.t)) << 1);
                k_w_reg[1] <= 24'({2'b0, wd_side.t} << 1);
            end
            else
            begin
                k_w_reg[0] <= wd_side.wov[0] ? WEIGHT_MAX : w_q[0][WQ_W];
                k_w_reg[1] <= wd_side.wov[1] ? WEIGHT_MAX : w_q[1][WQ_W];
            end
        end
    end

    // Stage L: weighted components
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_side_reg <= k_side_reg;
            for (int i = 0; i < 4; i++)
            begin
                l_pa_reg[i] <= $signed(k_side_reg.qa[i]) * $signed({1'b0, k_w_reg[0]});
                l_pb_reg[i] <= $signed(k_side_reg.qb[i]) * $signed({1'b0, k_w_reg[1]});
            end
        end
    end

    // Stage M: sums, signs and magnitudes
    always_comb
    begin
        m_side_next = l_side_reg;
        for (int i = 0; i < 4; i++)
        begin
            m_sum[i]           = 42'(l_pa_reg[i]) + 42'(l_pb_reg[i]);
            m_side_next.sgn[i] = m_sum[i][41];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= m_side_next;
            for (int i = 0; i < 4; i++)
            begin
                m_mag_reg[i] <= m_sum[i][41] ? 41'(-m_sum[i]) : m_sum[i][40:0];
            end
        end
    end

    // Stage N: fewest right shifts that bring every magnitude below 2^30
    always_comb
    begin
        n_or     = m_mag_reg[0] | m_mag_reg[1] | m_mag_reg[2] | m_mag_reg[3];
        n_k_next = '0;
        for (int i = 0; i < 11; i++)
        begin
            if (n_or[30 + i])
                n_k_next = 4'(i + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_side_reg <= m_side_reg;
            n_mag_reg  <= m_mag_reg;
            n_k_reg    <= n_k_next;
        end
    end

    // Stage O: apply the shift
    always_comb
    begin
        o_side_next = n_side_reg;
        for (int i = 0; i < 4; i++)
        begin
            o_side_next.mag[i] = 30'(n_mag_reg[i] >> n_k_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_side_reg <= o_side_next;
        end
    end

    // Stage P: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= o_side_reg;
            for (int i = 0; i < 4; i++)
            begin
                p_sq_reg[i] <= o_side_reg.mag[i] * o_side_reg.mag[i];
            end
        end
    end

    // Stage Q: sum of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_side_reg <= p_side_reg;
            q_sum_reg  <= 64'(p_sq_reg[0]) + 64'(p_sq_reg[1])
                        + 64'(p_sq_reg[2]) + 64'(p_sq_reg[3]);
        end
    end

    // Second root chain: vector length
    assign s2_v[0] = q_sum_reg;
    assign s2_r[0] = '0;
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt2
        qs_sqrt_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (s2_v[k]),
            .r_in  (s2_r[k]),
            .v_out (s2_v[k+1]),
            .r_out (s2_r[k+1])
        );
    end

    qs_delay #(.DEPTH(SQRT_STEPS)) u_dly_sqrt2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (q_vld_reg),
        .side_in  (q_side_reg),
        .vld_out  (s2_vld),
        .side_out (s2_side)
    );

    // Stage R: output divider setup and saturation check
    always_comb
    begin
        r_lim             = {16'b0, s2_r[SQRT_STEPS][31:0], 16'b0};
        r_side_next       = s2_side;
        r_side_next.lzero = (s2_r[SQRT_STEPS][31:0] == '0);
        for (int i = 0; i < 4; i++)
        begin
            r_num[i]           = {34'b0, s2_side.mag[i]} << FRAC_BITS;
            r_side_next.rov[i] = (r_num[i] >= r_lim);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_side_reg <= r_side_next;
            r_len_reg  <= s2_r[SQRT_STEPS][31:0];
            for (int i = 0; i < 4; i++)
            begin
                r_rem_reg[i] <= r_num[i][RREM_W-1:0];
            end
        end
    end

    // Output divider chains, one lane per component
    for (genvar l = 0; l < 4; l++) begin : g_odiv_lane
        assign o_rem[l][0] = r_rem_reg[l];
        assign o_d[l][0]   = r_len_reg;
        assign o_q[l][0]   = '0;
        for (genvar k = 0; k < RQ_W; k++) begin : g_odiv
            qs_div_cell #(
                .STEP (RQ_W - 1 - k),
                .RW   (RREM_W),
                .DW   (RD_W),
                .QW   (RQ_W)
            ) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (o_rem[l][k]),
                .d_in    (o_d[l][k]),
                .q_in    (o_q[l][k]),
                .rem_out (o_rem[l][k+1]),
                .d_out   (o_d[l][k+1]),
                .q_out   (o_q[l][k+1])
            );
        end
    end

    qs_delay #(.DEPTH(RQ_W)) u_dly_odiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (r_vld_reg),
        .side_in  (r_side_reg),
        .vld_out  (od_vld),
        .side_out (od_side)
    );

    // Stage S: sign, saturation, zero-length sum, small-angle bypass
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (od_side.below_lim)
                out_next[i] = od_side.qa[i];
            else if (od_side.lzero)
                out_next[i] = '0;
            else if (od_side.sgn[i])
                out_next[i] = (od_side.rov[i] || o_q[i][RQ_W] > 16'd32768)
                            ? 16'h8000 : 16'(-o_q[i][RQ_W]);
            else
                out_next[i] = (od_side.rov[i] || o_q[i][RQ_W] > 16'd32767)
                            ? 16'h7FFF : o_q[i][RQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_q_reg     <= out_next;
            out_small_reg <= od_side.below_lim;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_w       = out_q_reg[0];
    assign out_x       = out_q_reg[1];
    assign out_y       = out_q_reg[2];
    assign out_z       = out_q_reg[3];
    assign small_angle = out_small_reg;

endmodule

/* sv/qs_checker.sv */
// Port-level checks for quaternion_slerp, bound to the top level.
// Depends on the top-level port list only.
module qs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_wr_en,
    input logic [15:0]        cfg_wr_data,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] from_w,
    input logic signed [15:0] from_x,
    input logic signed [15:0] from_y,
    input logic signed [15:0] from_z,
    input logic signed [15:0] to_w,
    input logic signed [15:0] to_x,
    input logic signed [15:0] to_y,
    input logic signed [15:0] to_z,
    input logic [15:0]        fraction,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_w,
    input logic signed [15:0] out_x,
    input logic signed [15:0] out_y,
    input logic signed [15:0] out_z,
    input logic               small_angle
);

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_w) && $stable(out_x)
            && $stable(out_y) && $stable(out_z) && $stable(small_angle))
        else $error("result changed while stalled");

    // the input stalls only behind a held result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled without back-pressure");

    // back-pressure reaches the input in the same cycle
    a_stall_reach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while result held");

endmodule

bind quaternion_slerp qs_checker u_qs_checker (.*);

/* dv/quaternion_slerp_tb.sv */
// Testbench for quaternion_slerp: directed table plus random requests, checked
// against typed results or a bit-accurate in-bench predictor. Needs only the RTL.
`timescale 1ns / 100ps

module quaternion_slerp_tb;

    localparam int ITERS    = 16;
    localparam int FB       = 14;
    localparam int LATENCY  = 155;
    localparam int N_RANDOM = 630;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint HALF_PI_A = 102944;
    localparam longint PI_A      = 205887;
    localparam longint GAIN      = 652032874;
    localparam longint ONE30     = 1073741824;
    localparam longint WMAX      = 16777215;

    typedef struct packed {
        logic [15:0] w, x, y, z;
        logic        below_lim;
    } slerp_out_t;

    typedef struct {
        logic [15:0] q [8];
        logic [15:0] t;
        bit          typed;   // expected result typed in by hand
        slerp_out_t  res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] from_w = '0, from_x = '0, from_y = '0, from_z = '0;
    logic signed [15:0] to_w = '0, to_x = '0, to_y = '0, to_z = '0;
    logic [15:0] fraction = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] out_w, out_x, out_y, out_z;
    logic small_angle;

    slerp_out_t expected_q [$];
    int  n_errors = 0;
    int  n_results = 0;
    int  n_small = 0;
    longint cycles = 0;
    bit  no_idle = 1'b0;
    longint min_angle_m = 1;

    quaternion_slerp dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .from_w(from_w), .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_w(to_w), .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .fraction(fraction),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .small_angle(small_angle)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint atan_at(int i);
        longint tab [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
        return tab[i];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // arccos of a Q.30 value, Q.16 angle
    function automatic longint arccos_a(longint d30);
        longint x = (d30 < 0) ? -d30 : d30;
        longint y, z = 0, dx, dy;
        y = longint'(int_sqrt((64'd1 << 60) - longint'(x) * x));
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_at(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_at(i);
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_A) z = HALF_PI_A;
        return (d30 < 0) ? PI_A - z : z;
    endfunction

    function automatic longint sine_30(longint a);
        longint x = GAIN, y = 0, z, dx, dy;
        if (a > HALF_PI_A) a = PI_A - a;
        z = a;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_at(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_at(i);
            end
        end
        if (y < 0) y = 0;
        if (y > ONE30) y = ONE30;
        return y;
    endfunction

    function automatic longint unsigned blend_weight(longint part, longint whole);
        longint unsigned w = (longint'(part) << 16) / whole;
        return (w > WMAX) ? WMAX : w;
    endfunction

    function automatic slerp_out_t slerp_predict(logic [15:0] q [8], logic [15:0] tin);
        slerp_out_t r;
        longint qa [4], qb [4], sum [4];
        longint dot = 0, lim, alpha, ta, rest, sa, v;
        longint unsigned t, w0, w1, mag [4], maxm = 0, sq = 0, len, qt;
        int k = 0;
        logic [15:0] o [4];
        for (int i = 0; i < 4; i++)
        begin
            qa[i] = longint'($signed(q[i]));
            qb[i] = longint'($signed(q[4 + i]));
            dot += qa[i] * qb[i];
        end
        t = tin;
        if (t > 32768) t = 32768;
        lim = 64'sd1 << (2 * FB);
        if (dot > lim) dot = lim;
        if (dot < -lim) dot = -lim;
        alpha = arccos_a(dot <<< (30 - 2 * FB));
        if (alpha < min_angle_m)
        begin
            r = {q[0], q[1], q[2], q[3], 1'b1};
            return r;
        end
        ta = longint'((t * alpha + 16384) >> 15);
        rest = alpha - ta;
        sa = sine_30(alpha);
        if (sa == 0)
        begin
            w0 = (32768 - t) << 1;
            w1 = t << 1;
        end
        else
        begin
            w0 = blend_weight(sine_30(rest), sa);
            w1 = blend_weight(sine_30(ta), sa);
        end
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = qa[i] * longint'(w0) + qb[i] * longint'(w1);
            mag[i] = (sum[i] < 0) ? -sum[i] : sum[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        while ((maxm >> k) >= ONE30) k++;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] >>= k;
            sq += mag[i] * mag[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 4; i++)
        begin
            v = 0;
            if (len != 0)
            begin
                qt = (mag[i] << FB) / len;
                if (sum[i] < 0)
                    v = (qt > 32768) ? -32768 : -longint'(qt);
                else
                    v = (qt > 32767) ? 32767 : longint'(qt);
            end
            o[i] = v[15:0];
        end
        r = {o[0], o[1], o[2], o[3], 1'b0};
        return r;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quaternion_slerp_tb: errors");
            $finish;
        end
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);
        if (rst_n && out_valid && out_ready)
        begin
            slerp_out_t got, want;
            got = {out_w, out_x, out_y, out_z, small_angle};
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors <= n_errors + 1;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected w=%h x=%h y=%h z=%h s=%b",
                             $time, want.w, want.x, want.y, want.z, want.below_lim);
                    $display("%0t:          actual   w=%h x=%h y=%h z=%h s=%b",
                             $time, got.w, got.x, got.y, got.z, got.below_lim);
                    n_errors <= n_errors + 1;
                end
                n_results <= n_results + 1;
                if (got.below_lim) n_small <= n_small + 1;
            end
        end
    end

    // ---------------- request driving ----------------
    task automatic send_request(logic [15:0] q [8], logic [15:0] t, bit typed,
                                slerp_out_t res);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        from_w <= q[0]; from_x <= q[1]; from_y <= q[2]; from_z <= q[3];
        to_w <= q[4]; to_x <= q[5]; to_y <= q[6]; to_z <= q[7];
        fraction <= t;
        in_valid <= 1'b1;
        expected_q.push_back(typed ? res : slerp_predict(q, t));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_angle_m = val;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp(bit unit_scale);
        if (unit_scale) return 16'($signed($urandom_range(32768)) - 16384);
        return 16'($urandom);
    endfunction

    task automatic random_request(int mode);
        logic [15:0] q [8];
        logic [15:0] t;
        for (int i = 0; i < 8; i++)
            q[i] = rand_comp(mode != 0);
        if (mode == 2)   // nearly parallel pair
            for (int i = 0; i < 4; i++)
                q[4 + i] = q[i] + 16'($signed($urandom_range(8)) - 4);
        else if (mode == 3)   // nearly opposite pair
            for (int i = 0; i < 4; i++)
                q[4 + i] = -q[i] + 16'($signed($urandom_range(8)) - 4);
        t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        send_request(q, t, 1'b0, '0);
    endtask

    // ---------------- directed table ----------------
    stim_row_t dir_table [$];

    function automatic stim_row_t mk_row(int a0, int a1, int a2, int a3,
                                         int b0, int b1, int b2, int b3, int t);
        stim_row_t r;
        r.q = '{16'(a0), 16'(a1), 16'(a2), 16'(a3),
                16'(b0), 16'(b1), 16'(b2), 16'(b3)};
        r.t = 16'(t);
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    initial
    begin
        stim_row_t r;
        // identical unit quaternions: angle zero, start returned
        r = mk_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        r.typed = 1'b1;
        r.res = {16'd16384, 16'd0, 16'd0, 16'd0, 1'b1};
        dir_table.push_back(r);
        // dot clamp on oversize identical inputs, start returned
        r = mk_row(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 0);
        r.typed = 1'b1;
        r.res = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1};
        dir_table.push_back(r);
        dir_table.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        dir_table.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
        dir_table.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        dir_table.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 65535));
        dir_table.push_back(mk_row(16384, 0, 0, 0, 0, 16384, 0, 0, 32769));
        // opposite quaternions: zero sine, linear weights, zero-length sum
        dir_table.push_back(mk_row(16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        dir_table.push_back(mk_row(0, 16384, 0, 0, 0, -16384, 0, 0, 8192));
        dir_table.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 16384));
        dir_table.push_back(mk_row(0, 0, 0, 0, 16384, 0, 0, 0, 12345));
        dir_table.push_back(mk_row(32767, 32767, 32767, 32767, -32768, -32768,
                                   -32768, -32768, 20000));
        dir_table.push_back(mk_row(-32768, 0, 0, 0, 0, 0, 0, 32767, 1));
        dir_table.push_back(mk_row(11585, 11585, 0, 0, 16384, 0, 0, 0, 24576));
        dir_table.push_back(mk_row(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192, 100));
        dir_table.push_back(mk_row(16384, 0, 0, 0, 16383, 181, 0, 0, 16384));
        dir_table.push_back(mk_row(-1, -1, -1, -1, 1, 1, 1, 1, 32768));
        dir_table.push_back(mk_row(0, 0, 16384, 0, 0, 0, 0, -16384, 3));
    end

    // ---------------- main sequence ----------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_request(dir_table[i].q, dir_table[i].t, dir_table[i].typed,
                         dir_table[i].res);
        drain_pipe();

        // limit zero: every pair is interpolated
        write_limit(16'd0);
        send_request(dir_table[0].q, dir_table[0].t, 1'b0, '0);
        for (int i = 0; i < 120; i++) random_request($urandom_range(3));
        // sender holds off until the pipe is empty
        drain_pipe();

        // largest limit: pairs with an angle below 65535 (Q.16) take the short path
        write_limit(16'hffff);
        for (int i = 0; i < 40; i++) random_request($urandom_range(3));
        drain_pipe();

        write_limit(16'd1000);
        no_idle = 1'b1;
        for (int i = 0; i < 200; i++) random_request($urandom_range(3));
        no_idle = 1'b0;
        drain_pipe();

        write_limit(16'd1);
        for (int i = 0; i < N_RANDOM - 360; i++) random_request($urandom_range(3));
        drain_pipe();

        $display("Covered %0d results (%0d small angle) over limits 0, 1, 1000, 65535,",
                 n_results, n_small);
        $display("including clamped dots, opposite pairs and out-of-range fractions.");
        if (n_errors == 0 && expected_q.size() == 0)
            $display("quaternion_slerp_tb: clean");
        else
            $display("quaternion_slerp_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/qs_pkg.sv
sv/qs_sqrt_cell.sv
sv/qs_cordic_cell.sv
sv/qs_div_cell.sv
sv/qs_delay.sv
sv/quaternion_slerp.sv
sv/qs_checker.sv
dv/quaternion_slerp_tb.sv
